// ----- hdl/lee_pkg.sv -----
// Shared types, codes and constants of the line edit engine.
package lee_pkg;

    // Default depth of the line buffer.
    localparam int LEE_LINE_MAX_DEF = 40;

    // Character constants.
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] PRINT_LOW  = 8'd32;
    localparam logic [7:0] PRINT_HIGH = 8'd126;

    // Reset values of the configuration registers.
    localparam logic [7:0] ERASE_CODE_RST = 8'h7F;
    localparam logic [7:0] KILL_CODE_RST  = 8'h15;
    localparam logic [7:0] WORD_CODE_RST  = 8'h17;
    localparam logic [7:0] END_CODE_RST   = 8'h04;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ERASE = 2'd0;
    localparam logic [1:0] REG_KILL  = 2'd1;
    localparam logic [1:0] REG_WORD  = 2'd2;
    localparam logic [1:0] REG_END   = 2'd3;

    // Terminal actions carried with each result.
    typedef enum logic [1:0] {
        ACT_ECHO  = 2'd0,
        ACT_ERASE = 2'd1,
        ACT_BELL  = 2'd2,
        ACT_END   = 2'd3
    } action_t;

    // Class of the captured key byte, after the priority match.
    typedef enum logic [2:0] {
        KIND_ERASE = 3'd0,
        KIND_KILL  = 3'd1,
        KIND_WORD  = 3'd2,
        KIND_END   = 3'd3,
        KIND_PRINT = 3'd4,
        KIND_OTHER = 3'd5
    } kind_t;

    // Configuration register set.
    typedef struct packed {
        logic [7:0] erase_code;
        logic [7:0] kill_code;
        logic [7:0] word_erase_code;
        logic [7:0] end_code;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        logic    emit;
        action_t action;
        logic    last;
        logic    dec_fill;
        logic    wr_inc;
        logic    set_ended;
        logic    rd_en;
    } lee_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        kind_t kind;
        logic  fill_zero;
        logic  fill_one;
        logic  fill_full;
        logic  ended;
        logic  rd_space;
        logic  out_free;
    } lee_stat_t;

    // Address width for a store of the given depth.
    function automatic int lee_aw(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ----- hdl/lee_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lee_ram
    import lee_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = LEE_LINE_MAX_DEF
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [lee_aw(DEPTH)-1:0]  waddr,
    input  logic [WIDTH-1:0]          wdata,
    input  logic                      re,
    input  logic [lee_aw(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/lee_datapath.sv -----
// Datapath: key capture, key classification, fill count, line store and result register.
module lee_datapath
    import lee_pkg::*;
#(
    parameter int LINE_MAX = LEE_LINE_MAX_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic [7:0] key_byte,
    input  lee_cmd_t   cmd,
    output lee_stat_t  stat,
    input  logic       out_ready,
    output logic       out_valid,
    output action_t    out_action,
    output logic [7:0] out_echo,
    output logic       out_last
);

    localparam int AW = lee_aw(LINE_MAX);
    localparam int CW = $clog2(LINE_MAX + 1);

    logic [7:0]    key_reg;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] fill_m1;
    logic          ended_reg;
    logic          out_valid_reg;
    action_t       out_action_reg;
    logic [7:0]    out_echo_reg;
    logic          out_last_reg;
    logic [7:0]    rd_data;
    logic          out_free;
    kind_t         kind;

    // Capture the key byte of each accepted transaction.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            key_reg <= key_byte;
        end
    end

    // Priority match: erase, kill, word erase, end, then printable.
    always_comb begin
        if (key_reg == cfg.erase_code) begin
            kind = KIND_ERASE;
        end else if (key_reg == cfg.kill_code) begin
            kind = KIND_KILL;
        end else if (key_reg == cfg.word_erase_code) begin
            kind = KIND_WORD;
        end else if (key_reg == cfg.end_code) begin
            kind = KIND_END;
        end else if (key_reg >= PRINT_LOW && key_reg <= PRINT_HIGH) begin
            kind = KIND_PRINT;
        end else begin
            kind = KIND_OTHER;
        end
    end

    // Fill count and end-of-input flag.
    assign fill_m1 = fill_reg - CW'(1);

    always_comb begin
        fill_next = fill_reg;
        if (cmd.wr_inc) begin
            fill_next = fill_reg + CW'(1);
        end else if (cmd.dec_fill) begin
            fill_next = fill_m1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            ended_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            if (cmd.set_ended) begin
                ended_reg <= 1'b1;
            end
        end
    end

    // Line store: written at the fill count, read just below it.
    lee_ram #(
        .WIDTH (8),
        .DEPTH (LINE_MAX)
    ) u_line_store (
        .aclk  (aclk),
        .we    (cmd.wr_inc),
        .waddr (fill_reg[AW-1:0]),
        .wdata (key_reg),
        .re    (cmd.rd_en),
        .raddr (fill_m1[AW-1:0]),
        .rdata (rd_data)
    );

    // Result register; it takes a new result when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_action_reg <= cmd.action;
            out_echo_reg   <= (cmd.action == ACT_ECHO) ? key_reg : 8'd0;
            out_last_reg   <= cmd.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_action = out_action_reg;
    assign out_echo   = out_echo_reg;
    assign out_last   = out_last_reg;

    // Status toward the controller.
    always_comb begin
        stat.kind      = kind;
        stat.fill_zero = (fill_reg == '0);
        stat.fill_one  = (fill_reg == CW'(1));
        stat.fill_full = (fill_reg == CW'(LINE_MAX));
        stat.ended     = ended_reg;
        stat.rd_space  = (rd_data == SPACE_CHAR);
        stat.out_free  = out_free;
    end

endmodule

// ----- hdl/lee_ctrl.sv -----
// Controller: state machine that sequences each key byte into its results.
module lee_ctrl
    import lee_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  lee_stat_t stat,
    output lee_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECODE = 6'b000010,
        ST_KILL   = 6'b000100,
        ST_WE_RD  = 6'b001000,
        ST_WE_CHK = 6'b010000,
        ST_WE_FIN = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    // A word-erase result waiting until it is known whether it is the last.
    logic   pend_reg, pend_next;
    // Word erase has passed the trailing spaces and is in the word itself.
    logic   word_reg, word_next;
    logic   erase_now;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            word_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            word_reg  <= word_next;
        end
    end

    // In the space phase every character goes; in the word phase only non-spaces.
    assign erase_now = !word_reg || !stat.rd_space;

    always_comb begin
        state_next = state_reg;
        pend_next  = pend_reg;
        word_next  = word_reg;
        cmd        = '0;
        cmd.action = ACT_ERASE;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                // After end of input, transactions are taken and dropped.
                if (in_valid && !stat.ended) begin
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE: begin
                unique case (stat.kind)
                    KIND_ERASE: begin
                        if (stat.out_free) begin
                            cmd.emit     = 1'b1;
                            cmd.action   = stat.fill_zero ? ACT_BELL : ACT_ERASE;
                            cmd.last     = 1'b1;
                            cmd.dec_fill = !stat.fill_zero;
                            state_next   = ST_IDLE;
                        end
                    end
                    KIND_KILL: begin
                        state_next = stat.fill_zero ? ST_IDLE : ST_KILL;
                    end
                    KIND_WORD: begin
                        pend_next  = 1'b0;
                        word_next  = 1'b0;
                        state_next = ST_WE_RD;
                    end
                    KIND_END: begin
                        if (stat.out_free) begin
                            cmd.emit      = 1'b1;
                            cmd.action    = stat.fill_zero ? ACT_END : ACT_BELL;
                            cmd.last      = 1'b1;
                            cmd.set_ended = stat.fill_zero;
                            state_next    = ST_IDLE;
                        end
                    end
                    KIND_PRINT: begin
                        if (stat.out_free) begin
                            cmd.emit   = 1'b1;
                            cmd.action = stat.fill_full ? ACT_BELL : ACT_ECHO;
                            cmd.last   = 1'b1;
                            cmd.wr_inc = !stat.fill_full;
                            state_next = ST_IDLE;
                        end
                    end
                    KIND_OTHER: begin
                        if (stat.out_free) begin
                            cmd.emit   = 1'b1;
                            cmd.action = ACT_BELL;
                            cmd.last   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            // Kill: one erase result per character, the count tells the last one.
            ST_KILL: begin
                if (stat.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.action   = ACT_ERASE;
                    cmd.last     = stat.fill_one;
                    cmd.dec_fill = 1'b1;
                    if (stat.fill_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            // Word erase: read the character below the fill count.
            ST_WE_RD: begin
                if (stat.fill_zero) begin
                    state_next = ST_WE_FIN;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_WE_CHK;
                end
            end

            // Word erase: decide on the character just read.
            ST_WE_CHK: begin
                if (erase_now) begin
                    if (!pend_reg || stat.out_free) begin
                        cmd.emit     = pend_reg;
                        cmd.action   = ACT_ERASE;
                        cmd.last     = 1'b0;
                        cmd.dec_fill = 1'b1;
                        pend_next    = 1'b1;
                        word_next    = word_reg || !stat.rd_space;
                        state_next   = ST_WE_RD;
                    end
                end else begin
                    state_next = ST_WE_FIN;
                end
            end

            // Word erase: release the held result as the last one.
            ST_WE_FIN: begin
                if (!pend_reg) begin
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.action = ACT_ERASE;
                    cmd.last   = 1'b1;
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/line_edit_engine_top.sv -----
// Top level of the line edit engine: ports, configuration registers, controller and datapath.
//
// Channel   Direction  Handshake           Payload
// s_        in         s_tvalid/s_tready   s_tdata = key_byte
// m_        out        m_tvalid/m_tready   m_tdata = echo_byte, m_tuser = action, m_tlast = last
// APB       in         psel/penable/pready paddr, pwdata, prdata (four 8-bit code registers)
//
// One transaction is worked on at a time. A single-result key is captured, then
// classified and loaded into the result register; kill gives one erase result per
// character after capture and classify; word erase reads each erased character from
// the line store and then decides on it, and releases its held result as the last one.
// Stalls on m_tready hold the sequencer.
// Reset clears the fill count, the end flag and the registers to their defaults;
// the line store needs no clearing, as only written entries are ever read.
module line_edit_engine_top
    import lee_pkg::*;
#(
    parameter int LINE_MAX = LEE_LINE_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_byte
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] echo_byte
    output logic [1:0]  m_tuser,   // [1:0] action
    output logic        m_tlast,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t      cfg_reg;
    logic      cfg_wr;
    logic [1:0] reg_idx;
    lee_cmd_t  cmd;
    lee_stat_t stat;
    action_t   out_action;

    // Configuration register writes and reads.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.erase_code      <= ERASE_CODE_RST;
            cfg_reg.kill_code       <= KILL_CODE_RST;
            cfg_reg.word_erase_code <= WORD_CODE_RST;
            cfg_reg.end_code        <= END_CODE_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_ERASE: cfg_reg.erase_code      <= pwdata[7:0];
                REG_KILL:  cfg_reg.kill_code       <= pwdata[7:0];
                REG_WORD:  cfg_reg.word_erase_code <= pwdata[7:0];
                REG_END:   cfg_reg.end_code        <= pwdata[7:0];
                default:   cfg_reg.erase_code      <= cfg_reg.erase_code;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ERASE: prdata = {24'd0, cfg_reg.erase_code};
            REG_KILL:  prdata = {24'd0, cfg_reg.kill_code};
            REG_WORD:  prdata = {24'd0, cfg_reg.word_erase_code};
            REG_END:   prdata = {24'd0, cfg_reg.end_code};
            default:   prdata = 32'd0;
        endcase
    end

    // Sequencer.
    lee_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage and result register.
    lee_datapath #(
        .LINE_MAX (LINE_MAX)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .key_byte   (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_action (out_action),
        .out_echo   (m_tdata),
        .out_last   (m_tlast)
    );

    assign m_tuser = out_action;

`ifndef SYNTHESIS
    // Only an echo result carries a character.
    a_echo_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ACT_ECHO) |-> (m_tdata == 8'd0))
        else $error("non-echo result carries a character");

    // End of input is flagged only together with an end result.
    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(stat.ended) |-> $past(cmd.emit && (cmd.action == ACT_END)))
        else $error("end flag set without an end result");

    // One transaction at a time: the cycle after a live accept is busy.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !stat.ended |=> !s_tready)
        else $error("input taken while an item is in progress");

    // Nothing is emitted into a result register that is still held.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");
`endif

endmodule
